@@ rtl/locals_frame_stack_core_macros.svh @@
// assertion macros shared by the locals stack modules
`ifndef LOCALS_FRAME_STACK_CORE_MACROS_SVH
`define LOCALS_FRAME_STACK_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define LFS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define LFS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/lfs_pkg.sv @@
package lfs_pkg;

	// field widths
	localparam int CMD_W   = 3;
	localparam int IDX_W   = 8;
	localparam int VAL_W   = 64;
	localparam int KIND_W  = 2;
	localparam int STAT_W  = 2;
	localparam int DEPTH_W = 9;
	localparam int TDATA_W = 80;

	// command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_ENTER = 3'd0,
		CMD_LEAVE = 3'd1,
		CMD_PUSH  = 3'd2,
		CMD_GET   = 3'd3,
		CMD_SET   = 3'd4,
		CMD_CLEAR = 3'd5
	} cmd_t;

	// entry type tags
	typedef enum logic [KIND_W-1:0] {
		KIND_INT   = 2'd0,
		KIND_DINT  = 2'd1,
		KIND_FLOAT = 2'd2,
		KIND_MARK  = 2'd3
	} kind_t;

	// result status codes
	typedef enum logic [STAT_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_UNDER   = 2'd1,
		STAT_OVER    = 2'd2,
		STAT_NOFRAME = 2'd3
	} status_t;

	// one stack entry
	typedef struct packed {
		kind_t             tag;
		logic [VAL_W-1:0]  val;
	} entry_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic rd_en;
		logic exec;
	} ctl_t;

	// datapath to controller status
	typedef struct packed {
		logic out_free;
	} stat_t;

endpackage

@@ rtl/lfs_ctrl.sv @@
`include "locals_frame_stack_core_macros.svh"

module lfs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  lfs_pkg::stat_t stat,
	output lfs_pkg::ctl_t  ctl
);

	lfs_pkg::state_t state_q, state_n;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lfs_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// next state and commands
	always_comb begin
		state_n     = state_q;
		in_ready    = 1'b0;
		ctl.capture = 1'b0;
		ctl.rd_en   = 1'b0;
		ctl.exec    = 1'b0;
		unique case (state_q)
			lfs_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.capture = 1'b1;
					state_n     = lfs_pkg::ST_READ;
				end
			end
			lfs_pkg::ST_READ: begin
				ctl.rd_en = 1'b1;
				state_n   = lfs_pkg::ST_EXEC;
			end
			lfs_pkg::ST_EXEC: begin
				if (stat.out_free) begin
					ctl.exec = 1'b1;
					state_n  = lfs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = lfs_pkg::ST_IDLE;
			end
		endcase
	end

	`LFS_ASSERT_NXT(a_read_then_exec, state_q == lfs_pkg::ST_READ, state_q == lfs_pkg::ST_EXEC, "read not followed by exec")
	`LFS_ASSERT_IMP(a_exec_needs_room, ctl.exec, stat.out_free, "result loaded into a full output register")
	`LFS_ASSERT_NXT(a_capture_starts_read, ctl.capture, ctl.rd_en && !in_ready, "transaction capture not followed by a read")

endmodule

@@ rtl/lfs_dp.sv @@
`include "locals_frame_stack_core_macros.svh"

module lfs_dp #(
	parameter int STACK_DEPTH = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lfs_pkg::ctl_t                 ctl,
	output lfs_pkg::stat_t                stat,
	input  logic [lfs_pkg::CMD_W-1:0]     command,
	input  logic [lfs_pkg::IDX_W-1:0]     local_index,
	input  logic [lfs_pkg::VAL_W-1:0]     data_value,
	input  logic [lfs_pkg::KIND_W-1:0]    data_kind,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lfs_pkg::VAL_W-1:0]     read_value,
	output logic [lfs_pkg::KIND_W-1:0]    read_kind,
	output logic [lfs_pkg::STAT_W-1:0]    status,
	output logic [lfs_pkg::DEPTH_W-1:0]   stack_depth
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int SW = ((CW > lfs_pkg::IDX_W) ? CW : lfs_pkg::IDX_W) + 1;

	// entry memory
	lfs_pkg::entry_t mem [STACK_DEPTH];

	// captured transaction
	logic [lfs_pkg::CMD_W-1:0]  cmd_q;
	logic [lfs_pkg::IDX_W-1:0]  idx_q;
	logic [lfs_pkg::VAL_W-1:0]  data_q;
	logic [lfs_pkg::KIND_W-1:0] kind_q;

	// stack pointers
	logic [CW-1:0] count_q, fp_q;

	// registered memory read
	lfs_pkg::entry_t rd_q;

	// result register
	logic                         out_valid_q;
	logic [lfs_pkg::VAL_W-1:0]    rval_q;
	lfs_pkg::kind_t               rkind_q;
	lfs_pkg::status_t             stat_q;
	logic [lfs_pkg::DEPTH_W-1:0]  depth_q;

	// next values
	logic [SW-1:0]                slot;
	logic                         in_range;
	logic                         full;
	logic [CW-1:0]                fp_m1;
	logic [AW-1:0]                rd_addr;
	logic [CW-1:0]                count_n, fp_n;
	lfs_pkg::status_t             stat_n;
	logic [lfs_pkg::VAL_W-1:0]    rval_n;
	lfs_pkg::kind_t               rkind_n;
	logic                         wr_en;
	logic [AW-1:0]                wr_addr;
	lfs_pkg::entry_t              wr_data;
	lfs_pkg::kind_t               push_kind;

	assign stat.out_free = !out_valid_q || out_ready;

	// capture the accepted transaction
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q  <= command;
			idx_q  <= local_index;
			data_q <= data_value;
			kind_q <= data_kind;
		end
	end

	// address decode
	assign slot     = SW'(idx_q) + SW'(fp_q);
	assign in_range = slot < SW'(count_q);
	assign full     = count_q == CW'(STACK_DEPTH);
	assign fp_m1    = fp_q - CW'(1);
	assign rd_addr  = (cmd_q == lfs_pkg::CMD_LEAVE) ? fp_m1[AW-1:0] : slot[AW-1:0];
	assign push_kind = (lfs_pkg::kind_t'(kind_q) == lfs_pkg::KIND_MARK) ?
		lfs_pkg::KIND_INT : lfs_pkg::kind_t'(kind_q);

	// memory ports
	always_ff @(posedge clk) begin
		if (ctl.exec && wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// command execution
	always_comb begin
		count_n     = count_q;
		fp_n        = fp_q;
		stat_n      = lfs_pkg::STAT_OK;
		rval_n      = '0;
		rkind_n     = lfs_pkg::KIND_INT;
		wr_en       = 1'b0;
		wr_addr     = count_q[AW-1:0];
		wr_data.tag = lfs_pkg::KIND_MARK;
		wr_data.val = lfs_pkg::VAL_W'(fp_q);
		unique case (cmd_q)
			lfs_pkg::CMD_ENTER: begin
				if (full) begin
					stat_n = lfs_pkg::STAT_OVER;
				end else begin
					wr_en   = 1'b1;
					fp_n    = count_q + CW'(1);
					count_n = count_q + CW'(1);
				end
			end
			lfs_pkg::CMD_LEAVE: begin
				if (count_q == '0 || fp_q == '0 || fp_q > count_q ||
					rd_q.tag != lfs_pkg::KIND_MARK) begin
					stat_n = lfs_pkg::STAT_NOFRAME;
					fp_n   = '0;
				end else begin
					count_n = fp_m1;
					// saved pointer, clamped to the new top
					if (rd_q.val > lfs_pkg::VAL_W'(fp_m1)) begin
						fp_n = fp_m1;
					end else begin
						fp_n = rd_q.val[CW-1:0];
					end
				end
			end
			lfs_pkg::CMD_PUSH: begin
				if (full) begin
					stat_n = lfs_pkg::STAT_OVER;
				end else begin
					wr_en       = 1'b1;
					wr_data.tag = push_kind;
					wr_data.val = (push_kind == lfs_pkg::KIND_INT) ?
						{32'd0, data_q[31:0]} : data_q;
					count_n     = count_q + CW'(1);
				end
			end
			lfs_pkg::CMD_GET: begin
				if (!in_range || rd_q.tag == lfs_pkg::KIND_MARK) begin
					stat_n = lfs_pkg::STAT_UNDER;
				end else begin
					rval_n  = rd_q.val;
					rkind_n = rd_q.tag;
				end
			end
			lfs_pkg::CMD_SET: begin
				if (!in_range || rd_q.tag == lfs_pkg::KIND_MARK) begin
					stat_n = lfs_pkg::STAT_UNDER;
				end else begin
					// keep the stored type, narrow single ints
					wr_en       = 1'b1;
					wr_addr     = slot[AW-1:0];
					wr_data.tag = rd_q.tag;
					wr_data.val = (rd_q.tag == lfs_pkg::KIND_INT) ?
						{32'd0, data_q[31:0]} : data_q;
				end
			end
			lfs_pkg::CMD_CLEAR: begin
				count_n = '0;
				fp_n    = '0;
			end
			default: begin
			end
		endcase
	end

	// pointer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			fp_q    <= '0;
		end else if (ctl.exec) begin
			count_q <= count_n;
			fp_q    <= fp_n;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.exec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			rval_q  <= rval_n;
			rkind_q <= rkind_n;
			stat_q  <= stat_n;
			depth_q <= lfs_pkg::DEPTH_W'(count_n);
		end
	end

	assign out_valid   = out_valid_q;
	assign read_value  = rval_q;
	assign read_kind   = rkind_q;
	assign status      = stat_q;
	assign stack_depth = depth_q;

	`LFS_ASSERT_IMP(a_fp_in_stack, 1'b1, fp_q <= count_q, "frame pointer above stack top")
	`LFS_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(STACK_DEPTH), "entry count beyond depth")
	`LFS_ASSERT_NXT(a_full_push_holds, ctl.exec && full && cmd_q == lfs_pkg::CMD_PUSH, count_q == CW'(STACK_DEPTH) && stat_q == lfs_pkg::STAT_OVER, "push on full stack changed depth")

endmodule

@@ rtl/locals_frame_stack_core.sv @@
// locals frame stack: one command in, one result out per transaction
// a transaction is captured on acceptance, the entry memory read is registered, and the
// update and write back then load the result register once the output register is free;
// no new command is accepted until the result of the last one is loaded
// reset: entry count, frame pointer and handshake state clear; entry memory is not cleared
module locals_frame_stack_core #(
	parameter int STACK_DEPTH = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// command [2:0], local_index [10:3], data_value [74:11], zero [79:75]
	input  logic [lfs_pkg::TDATA_W-1:0]  s_tdata,
	// data_kind [1:0]
	input  logic [lfs_pkg::KIND_W-1:0]   s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// read_value [63:0], status [65:64], stack_depth [74:66], zero [79:75]
	output logic [lfs_pkg::TDATA_W-1:0]  m_tdata,
	// read_kind [1:0]
	output logic [lfs_pkg::KIND_W-1:0]   m_tuser
);

	lfs_pkg::ctl_t  ctl;
	lfs_pkg::stat_t stat;

	logic [lfs_pkg::VAL_W-1:0]   read_value;
	logic [lfs_pkg::STAT_W-1:0]  status;
	logic [lfs_pkg::DEPTH_W-1:0] stack_depth;

	// sequencer
	lfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.ctl      (ctl)
	);

	// stack storage and update
	lfs_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.stat        (stat),
		.command     (s_tdata[2:0]),
		.local_index (s_tdata[10:3]),
		.data_value  (s_tdata[74:11]),
		.data_kind   (s_tuser),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.read_value  (read_value),
		.read_kind   (m_tuser),
		.status      (status),
		.stack_depth (stack_depth)
	);

	// result packing
	assign m_tdata = {5'd0, stack_depth, status, read_value};

endmodule
